>>> rtl/core/histogram_2d_accumulator_core_defines.svh
// Assertion macros used by the histogram core checker.
`ifndef HISTOGRAM_2D_ACCUMULATOR_CORE_DEFINES_SVH
`define HISTOGRAM_2D_ACCUMULATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define HIST2_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("histogram core check failed");

// Next-cycle implication, disabled while reset is high.
`define HIST2_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("histogram core check failed");

`endif

>>> rtl/core/hist2_pkg.sv
// Shared types and constants of the two-dimensional histogram core.
package hist2_pkg;

   typedef enum logic [1:0] {
      OP_FILL_COORD = 2'd0,
      OP_FILL_INDEX = 2'd1,
      OP_READ       = 2'd2,
      OP_CLEAR      = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STS_OK        = 2'd0,
      STS_BELOW     = 2'd1,
      STS_ABOVE     = 2'd2,
      STS_BAD_INDEX = 2'd3
   } status_type;

   localparam logic [2:0] REG_X_ORIGIN = 3'd0;
   localparam logic [2:0] REG_X_WIDTH  = 3'd1;
   localparam logic [2:0] REG_X_COUNT  = 3'd2;
   localparam logic [2:0] REG_Y_ORIGIN = 3'd3;
   localparam logic [2:0] REG_Y_WIDTH  = 3'd4;
   localparam logic [2:0] REG_Y_COUNT  = 3'd5;

   localparam int QUOT_BITS = 7;
   localparam int OFF_BITS  = 17;
   localparam int DIV_BITS  = OFF_BITS + QUOT_BITS - 1;
   localparam int HITS_BITS = 32;
   localparam int TOTAL_BITS = 48;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_READ,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic                  start;
      logic [OFF_BITS-1:0]   x_off;
      logic [OFF_BITS-1:0]   y_off;
      logic [15:0]           x_w;
      logic [15:0]           y_w;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [QUOT_BITS-1:0]  x_quot;
      logic [QUOT_BITS-1:0]  y_quot;
   } div_rsp_type;

endpackage

>>> rtl/core/hist2_bin_div.sv
// Iterative restoring divider that turns axis offsets into bin indices.
module hist2_bin_div
   import hist2_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                 busy_ff, busy_in;
   logic [2:0]           step_ff, step_in;
   logic [OFF_BITS-1:0]  x_rem_ff, x_rem_in, y_rem_ff, y_rem_in;
   logic [15:0]          x_w_ff, y_w_ff;
   logic [QUOT_BITS-1:0] x_q_ff, x_q_in, y_q_ff, y_q_in;
   logic                 done_ff, done_in;
   logic [DIV_BITS-1:0]  x_trial, y_trial;

   // The quotient is known to stay below 128, so seven steps cover it.
   always_comb begin
      x_trial  = DIV_BITS'(x_w_ff) << step_ff;
      y_trial  = DIV_BITS'(y_w_ff) << step_ff;
      busy_in  = busy_ff;
      step_in  = step_ff;
      x_rem_in = x_rem_ff;
      y_rem_in = y_rem_ff;
      x_q_in   = x_q_ff;
      y_q_in   = y_q_ff;
      done_in  = 1'b0;
      if (div_req.start) begin
         busy_in  = 1'b1;
         step_in  = 3'(QUOT_BITS - 1);
         x_rem_in = div_req.x_off;
         y_rem_in = div_req.y_off;
         x_q_in   = '0;
         y_q_in   = '0;
      end else if (busy_ff) begin
         if (DIV_BITS'(x_rem_ff) >= x_trial) begin
            x_rem_in = x_rem_ff - OFF_BITS'(x_trial);
            x_q_in[step_ff] = 1'b1;
         end
         if (DIV_BITS'(y_rem_ff) >= y_trial) begin
            y_rem_in = y_rem_ff - OFF_BITS'(y_trial);
            y_q_in[step_ff] = 1'b1;
         end
         if (step_ff == 3'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff  <= step_in;
      x_rem_ff <= x_rem_in;
      y_rem_ff <= y_rem_in;
      x_q_ff   <= x_q_in;
      y_q_ff   <= y_q_in;
      if (div_req.start) begin
         x_w_ff <= div_req.x_w;
         y_w_ff <= div_req.y_w;
      end
   end

   assign div_rsp.done   = done_ff;
   assign div_rsp.x_quot = x_q_ff;
   assign div_rsp.y_quot = y_q_ff;

endmodule

>>> rtl/core/hist2_store.sv
// Bin store: one synchronous memory holding content and entry count per bin.
module hist2_store
   import hist2_pkg::*;
#(
   parameter int ADDR_BITS    = 12,
   parameter int DEPTH        = 4096,
   parameter int CONTENT_BITS = 40
)
(
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [ADDR_BITS-1:0]           wr_addr,
   input  logic signed [CONTENT_BITS-1:0] wr_content,
   input  logic [HITS_BITS-1:0]           wr_hits,
   input  logic                           rd_en,
   input  logic [ADDR_BITS-1:0]           rd_addr,
   output logic signed [CONTENT_BITS-1:0] rd_content,
   output logic [HITS_BITS-1:0]           rd_hits
);

   logic [CONTENT_BITS+HITS_BITS-1:0] mem [DEPTH];
   logic [CONTENT_BITS+HITS_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_content, wr_hits};
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_content = $signed(rd_data_ff[CONTENT_BITS+HITS_BITS-1:HITS_BITS]);
   assign rd_hits    = rd_data_ff[HITS_BITS-1:0];

endmodule

>>> rtl/core/histogram_2d_accumulator_core.sv
// Top level of the two-dimensional uniform-bin histogram core.
//
// Usage: a request transaction (req_valid high, req_stall low) carries one
// operation: fill by coordinate, fill by bin index, read a bin or clear all.
// Every request yields exactly one response transaction on the rsp_ channel,
// which carries the status, the addressed bin, its content and entry count,
// and the peak, floor and running totals after the operation.
// Configuration registers are written through csr_wr_en, csr_index and
// csr_wdata; the user must write them only while the core is idle, which the
// core does not enforce. A request passes the check state, then for a
// coordinate fill the seven steps of the shared bin divider, then the bin read
// and the update step that loads the response register; a clear or a request
// that fails its range check goes from check straight to update. The core
// works on one transaction at a time; the next request is taken in the cycle
// after the response register is loaded, except after a clear, which first
// runs the sweep. A request may enter while a response still waits at a
// stalled receiver. Reset and the clear operation start a sweep that zeroes
// every bin, one per cycle, MAX_X_BINS * MAX_Y_BINS bins (4096 by default),
// with req_stall high. While rsp_stall is high a finished response holds, and
// a new result waits in the update step until the response register frees up.
module histogram_2d_accumulator_core
   import hist2_pkg::*;
#(
   parameter int MAX_X_BINS   = 64,
   parameter int MAX_Y_BINS   = 64,
   parameter int CONTENT_BITS = 40
)
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [2:0]                     csr_index,
   input  logic [15:0]                    csr_wdata,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_operation,
   input  logic signed [15:0]             req_x_coord,
   input  logic signed [15:0]             req_y_coord,
   input  logic [5:0]                     req_col_sel,
   input  logic [5:0]                     req_row_sel,
   input  logic signed [23:0]             req_weight,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_status,
   output logic [5:0]                     rsp_found_col,
   output logic [5:0]                     rsp_found_row,
   output logic signed [CONTENT_BITS-1:0] rsp_content,
   output logic [31:0]                    rsp_hits,
   output logic signed [CONTENT_BITS-1:0] rsp_peak_content,
   output logic signed [CONTENT_BITS-1:0] rsp_floor_content,
   output logic signed [47:0]             rsp_grand_total,
   output logic [31:0]                    rsp_grand_hits
);

   localparam int DEPTH     = MAX_X_BINS * MAX_Y_BINS;
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW        = CONTENT_BITS;
   // Sum width wide enough for content plus a full 24-bit weight.
   localparam int SUM_BITS  = ((CW > 24) ? CW : 24) + 1;
   localparam int TSUM_BITS = TOTAL_BITS + 1;

   // Configuration registers.
   logic signed [15:0] x_origin_ff, y_origin_ff;
   logic [15:0]        x_width_ff, y_width_ff;
   logic [6:0]         x_count_ff, y_count_ff;

   // Captured request and per-item state.
   state_type              state_ff, state_in;
   op_type                 op_ff;
   logic signed [15:0]     x_ff, y_ff;
   logic signed [23:0]     w_ff;
   logic [QUOT_BITS-1:0]   col_ff, col_in, row_ff, row_in;
   status_type             status_ff, status_in;
   logic                   ok_ff, ok_in;
   logic [ADDR_BITS-1:0]   sweep_ff;
   logic                   sweep_last;

   // Accumulators.
   logic signed [CW-1:0]         peak_ff, peak_in, floor_ff, floor_in;
   logic signed [TOTAL_BITS-1:0] total_ff, total_in;
   logic [HITS_BITS-1:0]         ghits_ff, ghits_in;

   // Response register.
   logic                         rsp_valid_ff;
   status_type                   rsp_status_ff;
   logic [5:0]                   rsp_col_ff, rsp_row_ff;
   logic signed [CW-1:0]         rsp_content_ff, rsp_peak_ff, rsp_floor_ff;
   logic [HITS_BITS-1:0]         rsp_hits_ff, rsp_ghits_ff;
   logic signed [TOTAL_BITS-1:0] rsp_total_ff;

   // Control decoded from the state.
   logic req_take, mem_rd, rsp_load, out_free, sweep_run;

   // Effective axis settings.
   logic [6:0]  nx, ny;
   logic [15:0] wx, wy;

   always_comb begin
      if (x_count_ff == 7'd0) begin
         nx = 7'd1;
      end else if (int'(x_count_ff) > MAX_X_BINS) begin
         nx = 7'(MAX_X_BINS);
      end else begin
         nx = x_count_ff;
      end
      if (y_count_ff == 7'd0) begin
         ny = 7'd1;
      end else if (int'(y_count_ff) > MAX_Y_BINS) begin
         ny = 7'(MAX_Y_BINS);
      end else begin
         ny = y_count_ff;
      end
      wx = (x_width_ff == 16'd0) ? 16'd1 : x_width_ff;
      wy = (y_width_ff == 16'd0) ? 16'd1 : y_width_ff;
   end

   // Range check of a coordinate point against origin + width * count, and the index check against the bin counts.
   logic [22:0]          x_span, y_span;
   logic signed [24:0]   x_lim, y_lim;
   logic                 below, above;
   logic [OFF_BITS-1:0]  x_off, y_off;
   logic                 idx_bad;

   always_comb begin
      x_span  = 23'(wx) * 23'(nx);
      y_span  = 23'(wy) * 23'(ny);
      x_lim   = 25'(x_origin_ff) + $signed({2'b00, x_span});
      y_lim   = 25'(y_origin_ff) + $signed({2'b00, y_span});
      below   = (x_ff < x_origin_ff) || (y_ff < y_origin_ff);
      above   = (25'(x_ff) > x_lim) || (25'(y_ff) > y_lim);
      x_off   = OFF_BITS'(17'(x_ff) - 17'(x_origin_ff));
      y_off   = OFF_BITS'(17'(y_ff) - 17'(y_origin_ff));
      idx_bad = (col_ff >= nx) || (row_ff >= ny);
   end

   logic        div_start;
   div_req_type div_req;
   div_rsp_type div_rsp;

   assign div_req = '{start: div_start, x_off: x_off, y_off: y_off, x_w: wx, y_w: wy};

   hist2_bin_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Bin store and its address.
   logic [ADDR_BITS-1:0]  bin_addr, wr_addr;
   logic                  wr_en;
   logic signed [CW-1:0]  wr_content, rd_content;
   logic [HITS_BITS-1:0]  wr_hits, rd_hits;

   assign bin_addr = ADDR_BITS'(int'(row_ff) * MAX_X_BINS + int'(col_ff));

   hist2_store #(
      .ADDR_BITS    (ADDR_BITS),
      .DEPTH        (DEPTH),
      .CONTENT_BITS (CW)
   ) u_store (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_content (wr_content),
      .wr_hits    (wr_hits),
      .rd_en      (mem_rd),
      .rd_addr    (bin_addr),
      .rd_content (rd_content),
      .rd_hits    (rd_hits)
   );

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign sweep_last = (int'(sweep_ff) == DEPTH - 1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_SWEEP:  if (sweep_last) state_in = ST_IDLE;
         ST_IDLE:   if (req_valid) state_in = ST_CHECK;
         ST_CHECK: begin
            case (op_ff)
               OP_CLEAR: state_in = ST_UPDATE;
               OP_FILL_COORD: state_in = (below || above) ? ST_UPDATE : ST_DIV;
               default: state_in = idx_bad ? ST_UPDATE : ST_READ;
            endcase
         end
         ST_DIV:    if (div_rsp.done) state_in = ST_READ;
         ST_READ:   state_in = ST_UPDATE;
         ST_UPDATE: begin
            if (out_free) state_in = (op_ff == OP_CLEAR) ? ST_SWEEP : ST_IDLE;
         end
         default:   state_in = ST_SWEEP;
      endcase
   end

   // Control outputs of the sequencer.
   always_comb begin
      req_take  = 1'b0;
      mem_rd    = 1'b0;
      rsp_load  = 1'b0;
      sweep_run = 1'b0;
      div_start = 1'b0;
      case (state_ff)
         ST_SWEEP:  sweep_run = 1'b1;
         ST_IDLE:   req_take  = req_valid;
         ST_CHECK:  div_start = (op_ff == OP_FILL_COORD) && !below && !above;
         ST_READ:   mem_rd    = 1'b1;
         ST_UPDATE: rsp_load  = out_free;
         default:   sweep_run = 1'b0;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   // Check results and bin indices.
   logic [QUOT_BITS-1:0] qx_clamped, qy_clamped;

   always_comb begin
      qx_clamped = (div_rsp.x_quot >= nx) ? nx - 7'd1 : div_rsp.x_quot;
      qy_clamped = (div_rsp.y_quot >= ny) ? ny - 7'd1 : div_rsp.y_quot;
      col_in    = col_ff;
      row_in    = row_ff;
      status_in = status_ff;
      ok_in     = ok_ff;
      if (req_take) begin
         col_in    = {1'b0, req_col_sel};
         row_in    = {1'b0, req_row_sel};
         status_in = STS_OK;
         ok_in     = 1'b1;
      end else if (state_ff == ST_CHECK) begin
         case (op_ff)
            OP_CLEAR: begin
               ok_in  = 1'b0;
               col_in = '0;
               row_in = '0;
            end
            OP_FILL_COORD: begin
               if (below || above) begin
                  ok_in     = 1'b0;
                  status_in = below ? STS_BELOW : STS_ABOVE;
                  col_in    = '0;
                  row_in    = '0;
               end
            end
            default: begin
               if (idx_bad) begin
                  ok_in     = 1'b0;
                  status_in = STS_BAD_INDEX;
               end
            end
         endcase
      end else if (div_rsp.done) begin
         col_in = qx_clamped;
         row_in = qy_clamped;
      end
   end

   // Saturating updates of the bin and the accumulators.
   logic signed [SUM_BITS-1:0]  c_sum;
   logic signed [TSUM_BITS-1:0] t_sum;
   logic signed [CW-1:0]        c_new, out_content;
   logic [HITS_BITS-1:0]        h_new, out_hits;
   logic signed [TOTAL_BITS-1:0] t_new;
   logic                        is_fill;

   localparam logic signed [SUM_BITS-1:0] C_HI =
      SUM_BITS'((65'sd1 <<< (CW - 1)) - 65'sd1);
   localparam logic signed [SUM_BITS-1:0] C_LO = -C_HI - SUM_BITS'(1);
   localparam logic signed [TSUM_BITS-1:0] T_HI =
      TSUM_BITS'((65'sd1 <<< (TOTAL_BITS - 1)) - 65'sd1);
   localparam logic signed [TSUM_BITS-1:0] T_LO = -T_HI - TSUM_BITS'(1);

   always_comb begin
      is_fill = (op_ff == OP_FILL_COORD) || (op_ff == OP_FILL_INDEX);
      c_sum   = SUM_BITS'(rd_content) + SUM_BITS'(w_ff);
      if (c_sum > C_HI) begin
         c_new = CW'(C_HI);
      end else if (c_sum < C_LO) begin
         c_new = CW'(C_LO);
      end else begin
         c_new = CW'(c_sum);
      end
      h_new = (rd_hits == '1) ? rd_hits : rd_hits + 1'b1;
      t_sum = TSUM_BITS'(total_ff) + TSUM_BITS'(w_ff);
      if (t_sum > T_HI) begin
         t_new = TOTAL_BITS'(T_HI);
      end else if (t_sum < T_LO) begin
         t_new = TOTAL_BITS'(T_LO);
      end else begin
         t_new = TOTAL_BITS'(t_sum);
      end

      peak_in     = peak_ff;
      floor_in    = floor_ff;
      total_in    = total_ff;
      ghits_in    = ghits_ff;
      out_content = '0;
      out_hits    = '0;
      if (op_ff == OP_CLEAR) begin
         peak_in  = '0;
         floor_in = '0;
         total_in = '0;
         ghits_in = '0;
      end else if (ok_ff && is_fill) begin
         out_content = c_new;
         out_hits    = h_new;
         if (c_new > peak_ff) peak_in = c_new;
         if (c_new < floor_ff) floor_in = c_new;
         total_in = t_new;
         ghits_in = (ghits_ff == '1) ? ghits_ff : ghits_ff + 1'b1;
      end else if (ok_ff) begin
         out_content = rd_content;
         out_hits    = rd_hits;
      end

      // The sweep zeroes bins; otherwise a fill writes its updated bin back.
      wr_en      = sweep_run || (rsp_load && ok_ff && is_fill);
      wr_addr    = sweep_run ? sweep_ff : bin_addr;
      wr_content = sweep_run ? '0 : c_new;
      wr_hits    = sweep_run ? '0 : h_new;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         x_origin_ff  <= '0;
         x_width_ff   <= 16'd1;
         x_count_ff   <= 7'd64;
         y_origin_ff  <= '0;
         y_width_ff   <= 16'd1;
         y_count_ff   <= 7'd64;
         peak_ff      <= '0;
         floor_ff     <= '0;
         total_ff     <= '0;
         ghits_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (sweep_run) begin
            sweep_ff <= sweep_last ? '0 : sweep_ff + 1'b1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
            peak_ff      <= peak_in;
            floor_ff     <= floor_in;
            total_ff     <= total_in;
            ghits_ff     <= ghits_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            case (csr_index)
               REG_X_ORIGIN: x_origin_ff <= $signed(csr_wdata);
               REG_X_WIDTH:  x_width_ff  <= csr_wdata;
               REG_X_COUNT:  x_count_ff  <= csr_wdata[6:0];
               REG_Y_ORIGIN: y_origin_ff <= $signed(csr_wdata);
               REG_Y_WIDTH:  y_width_ff  <= csr_wdata;
               REG_Y_COUNT:  y_count_ff  <= csr_wdata[6:0];
               default: ;
            endcase
         end
      end
      if (req_take) begin
         op_ff <= op_type'(req_operation);
         x_ff  <= req_x_coord;
         y_ff  <= req_y_coord;
         w_ff  <= req_weight;
      end
      col_ff    <= col_in;
      row_ff    <= row_in;
      status_ff <= status_in;
      ok_ff     <= ok_in;
      if (rsp_load) begin
         rsp_status_ff  <= status_ff;
         rsp_col_ff     <= col_ff[5:0];
         rsp_row_ff     <= row_ff[5:0];
         rsp_content_ff <= out_content;
         rsp_hits_ff    <= out_hits;
         rsp_peak_ff    <= peak_in;
         rsp_floor_ff   <= floor_in;
         rsp_total_ff   <= total_in;
         rsp_ghits_ff   <= ghits_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_found_col     = rsp_col_ff;
   assign rsp_found_row     = rsp_row_ff;
   assign rsp_content       = rsp_content_ff;
   assign rsp_hits          = rsp_hits_ff;
   assign rsp_peak_content  = rsp_peak_ff;
   assign rsp_floor_content = rsp_floor_ff;
   assign rsp_grand_total   = rsp_total_ff;
   assign rsp_grand_hits    = rsp_ghits_ff;

endmodule

>>> rtl/core/hist2_checker.sv
// Port-level checker for the histogram core, bound to the top level.
`include "histogram_2d_accumulator_core_defines.svh"

module hist2_checker
   import hist2_pkg::*;
#(
   parameter int CONTENT_BITS = 40
)
(
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [1:0]                     rsp_status,
   input logic [5:0]                     rsp_found_col,
   input logic [5:0]                     rsp_found_row,
   input logic signed [CONTENT_BITS-1:0] rsp_content,
   input logic [31:0]                    rsp_hits,
   input logic signed [CONTENT_BITS-1:0] rsp_peak_content,
   input logic signed [CONTENT_BITS-1:0] rsp_floor_content
);

   logic                    rsp_held, rsp_err, rsp_range;
   logic                    bin_empty, bin_origin, in_bounds;
   logic [CONTENT_BITS+1:0] rsp_watch;

   assign rsp_held   = rsp_valid && rsp_stall;
   assign rsp_err    = rsp_valid && (rsp_status != STS_OK);
   assign rsp_range  = rsp_valid && ((rsp_status == STS_BELOW) || (rsp_status == STS_ABOVE));
   assign bin_empty  = (rsp_content == '0) && (rsp_hits == '0);
   assign bin_origin = (rsp_found_col == '0) && (rsp_found_row == '0);
   assign in_bounds  = (rsp_content <= rsp_peak_content) &&
                       (rsp_content >= rsp_floor_content);
   assign rsp_watch  = {rsp_status, rsp_content};

   `HIST2_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_watch))
   `HIST2_ASSERT_NOW(a_err_zero, clock, reset, rsp_err, bin_empty)
   `HIST2_ASSERT_NOW(a_range_bin, clock, reset, rsp_range, bin_origin)
   `HIST2_ASSERT_NOW(a_bounds, clock, reset, rsp_valid, in_bounds)

endmodule

bind histogram_2d_accumulator_core hist2_checker #(.CONTENT_BITS(CONTENT_BITS)) u_hist2_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_status        (rsp_status),
   .rsp_found_col     (rsp_found_col),
   .rsp_found_row     (rsp_found_row),
   .rsp_content       (rsp_content),
   .rsp_hits          (rsp_hits),
   .rsp_peak_content  (rsp_peak_content),
   .rsp_floor_content (rsp_floor_content)
);

>>> tb/tb.sv
// Self-checking testbench for the two-dimensional uniform-bin histogram core.
module tb;
   import hist2_pkg::*;

   localparam int NX_MAX = 64;
   localparam int NY_MAX = 64;
   localparam int CBITS  = 40;
   localparam logic [31:0] HITS_SAT = 32'hFFFF_FFFF;

   typedef struct packed {
      op_type             op;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [5:0]         col;
      logic [5:0]         row;
      logic signed [23:0] w;
   } bin_req_type;

   typedef struct packed {
      status_type         status;
      logic [5:0]         col;
      logic [5:0]         row;
      logic signed [39:0] content;
      logic [31:0]        hits;
      logic signed [39:0] peak;
      logic signed [39:0] floor;
      logic signed [47:0] total;
      logic [31:0]        grand_hits;
   } bin_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [2:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_operation = '0;
   logic signed [15:0] req_x_coord = '0, req_y_coord = '0;
   logic [5:0] req_col_sel = '0, req_row_sel = '0;
   logic signed [23:0] req_weight = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic [5:0] rsp_found_col, rsp_found_row;
   logic signed [39:0] rsp_content, rsp_peak_content, rsp_floor_content;
   logic [31:0] rsp_hits, rsp_grand_hits;
   logic signed [47:0] rsp_grand_total;

   histogram_2d_accumulator_core u_dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // Shadow copy of the bin store, the running registers and the axis setup.
   logic signed [39:0] bin_content [NX_MAX*NY_MAX];
   logic [31:0]        bin_hits [NX_MAX*NY_MAX];
   logic signed [39:0] peak_q, floor_q;
   logic signed [47:0] total_q;
   logic [31:0]        grand_hits_q;
   logic [15:0]        axis_reg [6];

   bin_req_type pending_reqs[$];
   bin_rsp_type expected_rsps[$];
   int  error_count = 0;
   int  rsp_seen = 0;
   int  fill_seen = 0;
   bit  calm = 0;        // when set, neither side idles

   function automatic logic signed [63:0] sat_sum(logic signed [63:0] a,
                                                  logic signed [63:0] b, int bits);
      logic signed [63:0] hi, lo, s;
      hi = (64'sd1 <<< (bits - 1)) - 1;
      lo = -hi - 1;
      s = a + b;
      if (s > hi) return hi;
      if (s < lo) return lo;
      return s;
   endfunction

   function automatic int axis_bins(logic [15:0] r, int maxb);
      int n;
      n = int'(r[6:0]);
      if (n < 1) n = 1;
      if (n > maxb) n = maxb;
      return n;
   endfunction

   function automatic void clear_histogram();
      foreach (bin_content[i]) begin
         bin_content[i] = '0;
         bin_hits[i] = '0;
      end
      peak_q = '0;
      floor_q = '0;
      total_q = '0;
      grand_hits_q = '0;
   endfunction

   // Appends one request to the queue that feeds the driver.
   function automatic void add_req(bin_req_type r);
      pending_reqs = {pending_reqs, r};
   endfunction

   // Computes the response of one request and updates the shadow histogram.
   function automatic bin_rsp_type histogram_step(bin_req_type r);
      bin_rsp_type o;
      int nx, ny, col, row, a;
      longint wx, wy, x0, y0, xv, yv;
      bit ok;
      logic signed [63:0] c;
      o = '0;
      o.status = STS_OK;
      nx = axis_bins(axis_reg[REG_X_COUNT], NX_MAX);
      ny = axis_bins(axis_reg[REG_Y_COUNT], NY_MAX);
      wx = (axis_reg[REG_X_WIDTH] == 0) ? 1 : longint'(axis_reg[REG_X_WIDTH]);
      wy = (axis_reg[REG_Y_WIDTH] == 0) ? 1 : longint'(axis_reg[REG_Y_WIDTH]);
      x0 = longint'($signed(axis_reg[REG_X_ORIGIN]));
      y0 = longint'($signed(axis_reg[REG_Y_ORIGIN]));
      xv = longint'(r.x);
      yv = longint'(r.y);
      col = int'(r.col);
      row = int'(r.row);
      ok = 1;
      if (r.op == OP_CLEAR) begin
         clear_histogram();
         ok = 0;
      end else if (r.op == OP_FILL_COORD) begin
         if (xv < x0 || yv < y0) begin
            o.status = STS_BELOW;
            ok = 0;
         end else if (xv > x0 + wx * nx || yv > y0 + wy * ny) begin
            o.status = STS_ABOVE;
            ok = 0;
         end else begin
            col = int'((xv - x0) / wx);
            row = int'((yv - y0) / wy);
            if (col >= nx) col = nx - 1;
            if (row >= ny) row = ny - 1;
         end
      end else if (col >= nx || row >= ny) begin
         o.status = STS_BAD_INDEX;
         o.col = r.col;
         o.row = r.row;
         ok = 0;
      end
      if (ok) begin
         a = row * NX_MAX + col;
         o.col = col[5:0];
         o.row = row[5:0];
         if (r.op != OP_READ) begin
            c = sat_sum(64'(bin_content[a]), 64'(r.w), CBITS);
            bin_content[a] = c[39:0];
            if (bin_hits[a] != HITS_SAT) bin_hits[a]++;
            if (c > 64'(peak_q)) peak_q = c[39:0];
            if (c < 64'(floor_q)) floor_q = c[39:0];
            c = sat_sum(64'(total_q), 64'(r.w), 48);
            total_q = c[47:0];
            if (grand_hits_q != HITS_SAT) grand_hits_q++;
         end
         o.content = bin_content[a];
         o.hits = bin_hits[a];
      end
      o.peak = peak_q;
      o.floor = floor_q;
      o.total = total_q;
      o.grand_hits = grand_hits_q;
      return o;
   endfunction

   function automatic bin_req_type make_req(op_type op, int x, int y, int col, int row,
                                            int w);
      bin_req_type r;
      r.op = op;
      r.x = x[15:0];
      r.y = y[15:0];
      r.col = col[5:0];
      r.row = row[5:0];
      r.w = w[23:0];
      return r;
   endfunction

   // Random request: mostly hits inside the configured axes, some noise.
   function automatic bin_req_type random_req();
      bin_req_type r;
      int pick, nx, ny, wx, wy, x0, y0;
      nx = axis_bins(axis_reg[REG_X_COUNT], NX_MAX);
      ny = axis_bins(axis_reg[REG_Y_COUNT], NY_MAX);
      wx = (axis_reg[REG_X_WIDTH] == 0) ? 1 : int'(axis_reg[REG_X_WIDTH]);
      wy = (axis_reg[REG_Y_WIDTH] == 0) ? 1 : int'(axis_reg[REG_Y_WIDTH]);
      x0 = int'($signed(axis_reg[REG_X_ORIGIN]));
      y0 = int'($signed(axis_reg[REG_Y_ORIGIN]));
      r.x = 16'($urandom());
      r.y = 16'($urandom());
      r.col = 6'($urandom());
      r.row = 6'($urandom());
      pick = int'($urandom_range(0, 9));
      if (pick < 5) begin
         r.w = 24'sd1;
      end else if (pick < 8) begin
         r.w = 24'(int'($urandom_range(0, 200)) - 100);
      end else begin
         r.w = 24'($urandom());
      end
      pick = int'($urandom_range(0, 99));
      if (pick < 45) begin
         r.op = OP_FILL_COORD;
         if ($urandom_range(0, 4) != 0) begin
            r.x = 16'(x0 + int'($urandom_range(0, wx * nx)));
            r.y = 16'(y0 + int'($urandom_range(0, wy * ny)));
         end
      end else if (pick < 75) begin
         r.op = OP_FILL_INDEX;
         if ($urandom_range(0, 5) != 0) begin
            r.col = 6'($urandom_range(0, nx - 1));
            r.row = 6'($urandom_range(0, ny - 1));
         end
      end else if (pick < 99) begin
         r.op = OP_READ;
         if ($urandom_range(0, 5) != 0) begin
            r.col = 6'($urandom_range(0, nx - 1));
            r.row = 6'($urandom_range(0, ny - 1));
         end
      end else begin
         r.op = OP_CLEAR;
      end
      return r;
   endfunction

   // Request driver: payload holds while stalled, valid drops only on idle.
   always @(posedge clock) begin
      bin_req_type r;
      if (!reset) begin
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() > 0 && (calm || $urandom_range(0, 99) >= 19)) begin
               r = pending_reqs.pop_front();
               expected_rsps = {expected_rsps, histogram_step(r)};
               req_valid     <= 1'b1;
               req_operation <= r.op;
               req_x_coord   <= r.x;
               req_y_coord   <= r.y;
               req_col_sel   <= r.col;
               req_row_sel   <= r.row;
               req_weight    <= r.w;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // The prediction above is made when the driver commits an item; since the
   // core takes requests in order, the shadow state stays in step with it.

   // Response monitor and random receiver stalls.
   always @(posedge clock) begin
      bin_rsp_type e;
      if (!reset) begin
         rsp_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 19);
         if (rsp_valid && !rsp_stall) begin
            rsp_seen++;
            if (expected_rsps.size() == 0) begin
               $error("response transaction with nothing expected");
               error_count++;
            end else begin
               e = expected_rsps.pop_front();
               if (e.status == STS_OK && e.hits != 0) fill_seen++;
               if (rsp_status != e.status) begin
                  $error("status expected %0d got %0d", e.status, rsp_status);
                  error_count++;
               end
               if (rsp_found_col != e.col) begin
                  $error("found_col expected %0d got %0d", e.col, rsp_found_col);
                  error_count++;
               end
               if (rsp_found_row != e.row) begin
                  $error("found_row expected %0d got %0d", e.row, rsp_found_row);
                  error_count++;
               end
               if (rsp_content != e.content) begin
                  $error("content expected %0d got %0d", e.content, rsp_content);
                  error_count++;
               end
               if (rsp_hits != e.hits) begin
                  $error("hits expected %0d got %0d", e.hits, rsp_hits);
                  error_count++;
               end
               if (rsp_peak_content != e.peak) begin
                  $error("peak_content expected %0d got %0d", e.peak, rsp_peak_content);
                  error_count++;
               end
               if (rsp_floor_content != e.floor) begin
                  $error("floor_content expected %0d got %0d", e.floor,
                         rsp_floor_content);
                  error_count++;
               end
               if (rsp_grand_total != e.total) begin
                  $error("grand_total expected %0d got %0d", e.total, rsp_grand_total);
                  error_count++;
               end
               if (rsp_grand_hits != e.grand_hits) begin
                  $error("grand_hits expected %0d got %0d", e.grand_hits,
                         rsp_grand_hits);
                  error_count++;
               end
            end
         end
      end
   end

   // Waits until every queued request has been answered, then lets the clock run on idle.
   task automatic drain_all();
      while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || req_valid)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_axis(logic [2:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      axis_reg[idx] = val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic setup_axes(logic [15:0] x0, logic [15:0] xw, logic [15:0] xn,
                             logic [15:0] y0, logic [15:0] yw, logic [15:0] yn);
      write_axis(REG_X_ORIGIN, x0);
      write_axis(REG_X_WIDTH, xw);
      write_axis(REG_X_COUNT, xn);
      write_axis(REG_Y_ORIGIN, y0);
      write_axis(REG_Y_WIDTH, yw);
      write_axis(REG_Y_COUNT, yn);
   endtask

   task automatic random_phase(int n);
      repeat (n) add_req(random_req());
      drain_all();
   endtask

   initial begin
      clear_histogram();
      axis_reg[REG_X_ORIGIN] = 16'd0;
      axis_reg[REG_X_WIDTH]  = 16'd1;
      axis_reg[REG_X_COUNT]  = 16'd64;
      axis_reg[REG_Y_ORIGIN] = 16'd0;
      axis_reg[REG_Y_WIDTH]  = 16'd1;
      axis_reg[REG_Y_COUNT]  = 16'd64;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part on the reset axes: edges and every operation.
      add_req(make_req(OP_FILL_COORD, 0, 0, 0, 0, 1));
      add_req(make_req(OP_FILL_COORD, 64, 64, 0, 0, 5));   // top edge
      add_req(make_req(OP_FILL_COORD, -1, 3, 0, 0, 1));    // below
      add_req(make_req(OP_FILL_COORD, 3, 65, 0, 0, 1));    // above
      add_req(make_req(OP_FILL_COORD, -32768, 32767, 0, 0, 1));
      add_req(make_req(OP_FILL_COORD, 32767, 0, 0, 0, 1));
      add_req(make_req(OP_FILL_INDEX, 0, 0, 63, 63, 8388607));
      add_req(make_req(OP_FILL_INDEX, 0, 0, 0, 63, -8388608));
      add_req(make_req(OP_READ, 0, 0, 63, 63, 0));
      add_req(make_req(OP_READ, 0, 0, 63, 0, 0));
      // Drive one bin up with the largest weight, then clear and read it back.
      repeat (3) add_req(make_req(OP_FILL_INDEX, 0, 0, 5, 5, 8388607));
      drain_all();
      add_req(make_req(OP_CLEAR, 0, 0, 0, 0, 0));
      add_req(make_req(OP_READ, 0, 0, 5, 5, 0));
      drain_all();

      // Narrow axes with odd widths; index checks against a small bin count.
      setup_axes(16'hFF38, 16'd7, 16'd5, 16'd100, 16'd3, 16'd4);
      add_req(make_req(OP_FILL_INDEX, 0, 0, 5, 0, 1));     // bad col
      add_req(make_req(OP_READ, 0, 0, 0, 4, 0));           // bad row
      add_req(make_req(OP_FILL_COORD, -165, 112, 0, 0, 2)); // top edge
      add_req(make_req(OP_FILL_COORD, -164, 112, 0, 0, 2)); // above
      drain_all();
      random_phase(120);

      // Zero widths and zero counts act as one; out-of-range counts clamp.
      setup_axes(16'h8000, 16'd0, 16'd0, 16'h7FFF, 16'd0, 16'd127);
      random_phase(80);
      setup_axes(16'h8000, 16'hFFFF, 16'd64, 16'h8000, 16'hFFFF, 16'd64);
      random_phase(80);

      // A stretch with no idling on either side.
      setup_axes(16'd0, 16'd1, 16'd64, 16'd0, 16'd1, 16'd64);
      calm = 1;
      random_phase(150);
      calm = 0;

      setup_axes(16'hFFF0, 16'd2, 16'd16, 16'hFFE0, 16'd5, 16'd9);
      random_phase(250);

      $display("Covered %0d responses over six axis setups, %0d on bins with entries.",
               rsp_seen, fill_seen);
      if (error_count == 0) begin
         $display("histogram_2d_accumulator_core test passed");
      end else begin
         $display("histogram_2d_accumulator_core test failed");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("histogram_2d_accumulator_core test failed");
      $finish;
   end

endmodule
